// File: hw/rtl/multichannel_input_debouncer_top_assert.svh
// assertion macros used by the debouncer back end (mcid_back)
`ifndef MULTICHANNEL_INPUT_DEBOUNCER_TOP_ASSERT_SVH
`define MULTICHANNEL_INPUT_DEBOUNCER_TOP_ASSERT_SVH

// same-cycle implication
`define MCID_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("debouncer assertion failed");

// next-cycle implication
`define MCID_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("debouncer assertion failed");

`endif

// File: hw/rtl/mcid_pkg.sv
package mcid_pkg;

  localparam int NUM_CHANNELS = 64;
  localparam int CH_W         = 6;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
  localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  localparam logic [9:0]  CENTER_RST = 10'd512;
  localparam logic [9:0]  DEAD_RST   = 10'd100;
  localparam logic [15:0] SETTLE_RST = 16'd50;
  localparam logic [63:0] ENABLE_RST = '1;
  localparam logic [63:0] MANUAL_RST = '0;

  typedef enum logic [2:0] {
    REG_CENTER    = 3'd0,
    REG_DEAD_BAND = 3'd1,
    REG_SETTLE    = 3'd2,
    REG_ENABLE    = 3'd3,
    REG_MANUAL    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_DIGITAL = 2'd0,
    KIND_LOW     = 2'd1,
    KIND_HIGH    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic [1:0]      sample_kind;
    logic [9:0]      raw_value;
    logic [31:0]     time_ms;
  } sample_t;

  typedef struct packed {
    logic [CH_W-1:0] event_channel;
    logic            is_manual;
    logic            new_level;
  } report_t;

  typedef struct packed {
    logic [9:0]  center_value;
    logic [9:0]  dead_band;
    logic [15:0] settle_ms;
    logic [63:0] enable_mask;
    logic [63:0] manual_mask;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            lvl;
    logic            manual;
    logic [31:0]     time_ms;
  } cls_t;

  // per-channel debounce state
  typedef struct packed {
    logic        stable;
    logic        cand;
    logic [31:0] stamp;
  } chan_state_t;

endpackage

// File: hw/rtl/multichannel_input_debouncer_top.sv
// multichannel time-window debouncer: each word pushed in is one timestamped
// sample of one channel (digital pulled-up pin, or joystick adc low / high side
// against center_value -/+ dead_band); a channel's stable level changes, and a
// report word is queued, once its new level has held strictly longer than
// settle_ms (elapsed time taken modulo 2^32, so timestamp wrap is fine).
// samples of disabled channels and of the unused kind are dropped silently.
// throughput is one sample word per clock while the report queue is not full,
// sustained, same channel back to back included; the update stage writes each
// report into the result queue. the rate is set by the single read port of the
// 64-entry channel state memory, read in the read stage and written back by the
// update stage, with the last write forwarded. reset clears all channel state
// at once through per-entry valid bits, so no clearing pass is needed. config
// registers sit on the apb port at byte address 8*i: center_value, dead_band,
// settle_ms, enable_mask, manual_mask; write them only while the block is idle.
module multichannel_input_debouncer_top (
  input  logic                          clk,
  input  logic                          rst,
  // apb config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcid_pkg::PADDR_W-1:0]  paddr,
  input  logic [mcid_pkg::PDATA_W-1:0]  pwdata,
  output logic [mcid_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // sample side
  input  logic                          push,
  input  mcid_pkg::sample_t             sample,
  output logic                          full,
  // report side
  output logic                          empty,
  input  logic                          pop,
  output mcid_pkg::report_t             report
);

  mcid_pkg::cfg_t cfg;
  logic [2:0]     reg_sel;
  logic           cfg_wr;

  logic           mq_push;
  logic           mq_pop;
  logic           mq_full;
  logic           mq_empty;
  mcid_pkg::cls_t cls;
  mcid_pkg::cls_t mq_head;

  // register file, pready tied high so a write lands in the access cycle
  assign pready  = 1'b1;
  assign reg_sel = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_value <= mcid_pkg::CENTER_RST;
      cfg.dead_band    <= mcid_pkg::DEAD_RST;
      cfg.settle_ms    <= mcid_pkg::SETTLE_RST;
      cfg.enable_mask  <= mcid_pkg::ENABLE_RST;
      cfg.manual_mask  <= mcid_pkg::MANUAL_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        mcid_pkg::REG_CENTER:    cfg.center_value <= pwdata[9:0];
        mcid_pkg::REG_DEAD_BAND: cfg.dead_band    <= pwdata[9:0];
        mcid_pkg::REG_SETTLE:    cfg.settle_ms    <= pwdata[15:0];
        mcid_pkg::REG_ENABLE:    cfg.enable_mask  <= pwdata;
        mcid_pkg::REG_MANUAL:    cfg.manual_mask  <= pwdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (reg_sel)
      mcid_pkg::REG_CENTER:    prdata = mcid_pkg::PDATA_W'(cfg.center_value);
      mcid_pkg::REG_DEAD_BAND: prdata = mcid_pkg::PDATA_W'(cfg.dead_band);
      mcid_pkg::REG_SETTLE:    prdata = mcid_pkg::PDATA_W'(cfg.settle_ms);
      mcid_pkg::REG_ENABLE:    prdata = cfg.enable_mask;
      mcid_pkg::REG_MANUAL:    prdata = cfg.manual_mask;
      default:                 prdata = '0;
    endcase
  end

  // front: classify the sample into a level, drop ignored words
  mcid_front u_front (
    .push    (push),
    .sample  (sample),
    .cfg     (cfg),
    .mq_full (mq_full),
    .full    (full),
    .mq_push (mq_push),
    .cls     (cls)
  );

  // short queue so front and back stall independently
  mcid_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (mq_push),
    .wdata (cls),
    .rd_en (mq_pop),
    .full  (mq_full),
    .empty (mq_empty),
    .head  (mq_head)
  );

  // back: per-channel state read-modify-write and report queue
  mcid_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mq_empty  (mq_empty),
    .mq_head   (mq_head),
    .mq_pop    (mq_pop),
    .settle_ms (cfg.settle_ms),
    .pop       (pop),
    .empty     (empty),
    .report    (report)
  );

endmodule

// File: hw/rtl/mcid_front.sv
module mcid_front (
  input  logic              push,
  input  mcid_pkg::sample_t sample,
  input  mcid_pkg::cfg_t    cfg,
  input  logic              mq_full,
  output logic              full,
  output logic              mq_push,
  output mcid_pkg::cls_t    cls
);

  logic ch_ok;
  logic kind_ok;
  logic lvl;
  logic keep;

  // channel range check, level decode per sample kind
  always_comb begin
    ch_ok   = ({1'b0, sample.channel} < (mcid_pkg::CH_W + 1)'(mcid_pkg::NUM_CHANNELS));
    kind_ok = 1'b1;
    lvl     = 1'b0;
    unique case (sample.sample_kind)
      mcid_pkg::KIND_DIGITAL: lvl = ~sample.raw_value[0];
      mcid_pkg::KIND_LOW: begin
        lvl = (({1'b0, sample.raw_value} + {1'b0, cfg.dead_band}) < {1'b0, cfg.center_value});
      end
      mcid_pkg::KIND_HIGH: begin
        lvl = ({1'b0, sample.raw_value} > ({1'b0, cfg.center_value} + {1'b0, cfg.dead_band}));
      end
      default: kind_ok = 1'b0;
    endcase
  end

  assign keep        = ch_ok && kind_ok && cfg.enable_mask[sample.channel];
  assign full        = mq_full;
  assign mq_push     = push && !mq_full && keep;
  assign cls.ch      = sample.channel;
  assign cls.lvl     = lvl;
  assign cls.manual  = cfg.manual_mask[sample.channel];
  assign cls.time_ms = sample.time_ms;

endmodule

// File: hw/rtl/mcid_queue.sv
module mcid_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  mcid_pkg::cls_t wdata,
  input  logic           rd_en,
  output logic           full,
  output logic           empty,
  output mcid_pkg::cls_t head
);

  mcid_pkg::cls_t                  slots [mcid_pkg::MQ_DEPTH];
  logic [mcid_pkg::MQ_PTR_W-1:0]   wp;
  logic [mcid_pkg::MQ_PTR_W-1:0]   rp;
  logic [mcid_pkg::MQ_CNT_W-1:0]   cnt;
  logic                            do_wr;
  logic                            do_rd;

  assign full  = (cnt == mcid_pkg::MQ_CNT_W'(mcid_pkg::MQ_DEPTH));
  assign empty = (cnt == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        wp <= wp + 1'b1;
      end
      if (do_rd) begin
        rp <= rp + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/mcid_back.sv
`include "multichannel_input_debouncer_top_assert.svh"

module mcid_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              mq_empty,
  input  mcid_pkg::cls_t    mq_head,
  output logic              mq_pop,
  input  logic [15:0]       settle_ms,
  input  logic              pop,
  output logic              empty,
  output mcid_pkg::report_t report
);

  // channel state memory, valid bits stand in for the reset value
  mcid_pkg::chan_state_t         st_mem [mcid_pkg::NUM_CHANNELS];
  logic [mcid_pkg::NUM_CHANNELS-1:0] st_vld;

  mcid_pkg::chan_state_t         rd_word;
  logic                          rd_vld;

  logic                          s2_vld;
  mcid_pkg::cls_t                s2;

  // last write, forwarded to a word read at the same edge
  logic                          lw_vld;
  logic [mcid_pkg::CH_W-1:0]     lw_ch;
  mcid_pkg::chan_state_t         lw_state;

  mcid_pkg::chan_state_t         cur;
  mcid_pkg::chan_state_t         nxt;
  logic                          cand_chg;
  logic [31:0]                   elapsed;
  logic                          fire;
  logic                          advance;
  logic                          wr_en;
  logic                          oq_push;
  logic                          oq_pop;
  logic                          oq_full;

  mcid_pkg::report_t             oq [mcid_pkg::OQ_DEPTH];
  logic [mcid_pkg::OQ_PTR_W-1:0] oq_wp;
  logic [mcid_pkg::OQ_PTR_W-1:0] oq_rp;
  logic [mcid_pkg::OQ_CNT_W-1:0] oq_cnt;

  assign oq_full = (oq_cnt == mcid_pkg::OQ_CNT_W'(mcid_pkg::OQ_DEPTH));
  assign advance = !oq_full;
  assign mq_pop  = advance && !mq_empty;
  assign wr_en   = s2_vld && advance;

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (advance) begin
      s2_vld <= !mq_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2      <= mq_head;
      rd_word <= st_mem[mq_head.ch[mcid_pkg::CH_IDX_W-1:0]];
      rd_vld  <= st_vld[mq_head.ch[mcid_pkg::CH_IDX_W-1:0]];
    end
  end

  // update stage
  always_comb begin
    if (lw_vld && (lw_ch == s2.ch)) begin
      cur = lw_state;
    end else if (rd_vld) begin
      cur = rd_word;
    end else begin
      cur = '0;
    end
    cand_chg   = (s2.lvl != cur.cand);
    elapsed    = s2.time_ms - cur.stamp;
    fire       = !cand_chg && (cur.cand != cur.stable) && (elapsed > {16'b0, settle_ms});
    nxt.cand   = s2.lvl;
    nxt.stamp  = cand_chg ? s2.time_ms : cur.stamp;
    nxt.stable = fire ? cur.cand : cur.stable;
  end

  assign oq_push = wr_en && fire;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      st_mem[s2.ch[mcid_pkg::CH_IDX_W-1:0]] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_ch    <= s2.ch;
      lw_state <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
      lw_vld <= 1'b0;
    end else if (wr_en) begin
      st_vld[s2.ch[mcid_pkg::CH_IDX_W-1:0]] <= 1'b1;
      lw_vld <= 1'b1;
    end
  end

  // result queue
  assign empty  = (oq_cnt == '0);
  assign oq_pop = pop && !empty;
  assign report = oq[oq_rp];

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wp].event_channel <= s2.ch;
      oq[oq_wp].is_manual     <= s2.manual;
      oq[oq_wp].new_level     <= cur.cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp  <= '0;
      oq_rp  <= '0;
      oq_cnt <= '0;
    end else begin
      if (oq_push) begin
        oq_wp <= oq_wp + 1'b1;
      end
      if (oq_pop) begin
        oq_rp <= oq_rp + 1'b1;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt <= oq_cnt + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt <= oq_cnt - 1'b1;
      end
    end
  end

  `MCID_ASSERT_NEXT(a_s2_hold, clk, rst, s2_vld && !advance, s2_vld && $stable(s2.ch))
  `MCID_ASSERT_NEXT(a_fire_sets_stable, clk, rst, oq_push, lw_vld && (lw_state.stable == $past(cur.cand)))
  `MCID_ASSERT_IMPLY(a_oq_bound, clk, rst, 1'b1, oq_cnt <= mcid_pkg::OQ_CNT_W'(mcid_pkg::OQ_DEPTH))
  `MCID_ASSERT_NEXT(a_oq_grow, clk, rst, oq_push && !oq_pop, oq_cnt == mcid_pkg::OQ_CNT_W'($past(oq_cnt) + 1'b1))

endmodule
